[hw/rtl/itf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_pkg: shared definitions for the integer to text formatter
// Codes, sizes, character constants, the microcode word and its program ROM.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int LONG_BITS    = 32;
  localparam int MAX_WIDTH    = 63;
  localparam int VAL_W        = 64;
  localparam int NUM_DIGITS   = 22;            // octal of a 64-bit value
  localparam int DEC_DIGITS   = 20;            // decimal of a 64-bit value
  localparam int DABBLE_BITS  = 4;             // binary bits consumed per cycle
  localparam int DABBLE_STEPS = VAL_W / DABBLE_BITS;
  localparam int CV_W         = $clog2(DABBLE_STEPS + 1);
  localparam int DIG_IDX_W    = $clog2(NUM_DIGITS);
  localparam int CNT_W        = 6;
  localparam int NUM_SEGS     = 6;
  localparam int MAX_PREC     = 62;

  // conversion kinds
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_HEXU = 3'd4;

  // size codes
  localparam logic [2:0] SIZE_INT   = 3'd0;
  localparam logic [2:0] SIZE_CHAR  = 3'd1;
  localparam logic [2:0] SIZE_SHORT = 3'd2;
  localparam logic [2:0] SIZE_LONG  = 3'd3;
  localparam logic [2:0] SIZE_LLONG = 3'd4;

  // ASCII
  localparam logic [7:0] ASC_SPACE = 8'h20;
  localparam logic [7:0] ASC_PLUS  = 8'h2B;
  localparam logic [7:0] ASC_MINUS = 8'h2D;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_NINE  = 8'h39;
  localparam logic [7:0] ASC_UA    = 8'h41;
  localparam logic [7:0] ASC_UF    = 8'h46;
  localparam logic [7:0] ASC_LA    = 8'h61;
  localparam logic [7:0] ASC_LF    = 8'h66;

  typedef logic [3:0] step_t;
  typedef logic [2:0] op_t;
  typedef logic [2:0] cond_t;
  typedef logic [2:0] sel_t;
  typedef logic [1:0] chr_t;

  // datapath operations
  localparam op_t OP_NOP   = 3'd0;
  localparam op_t OP_WAIT  = 3'd1;
  localparam op_t OP_CHECK = 3'd2;
  localparam op_t OP_CONV  = 3'd3;
  localparam op_t OP_LEN   = 3'd4;
  localparam op_t OP_PLAN  = 3'd5;
  localparam op_t OP_EMIT  = 3'd6;

  // jump conditions: taken -> jmp, else step + 1
  localparam cond_t C_NEVER   = 3'd0;
  localparam cond_t C_ALWAYS  = 3'd1;
  localparam cond_t C_NOXFER  = 3'd2;
  localparam cond_t C_BADKIND = 3'd3;
  localparam cond_t C_CONV_NZ = 3'd4;
  localparam cond_t C_SEG_NZ  = 3'd5;

  // segment counters
  localparam sel_t SEL_PADL = 3'd0;
  localparam sel_t SEL_SIGN = 3'd1;
  localparam sel_t SEL_PADZ = 3'd2;
  localparam sel_t SEL_LEAD = 3'd3;
  localparam sel_t SEL_DIG  = 3'd4;
  localparam sel_t SEL_PADR = 3'd5;

  // character sources
  localparam chr_t CH_SPACE = 2'd0;
  localparam chr_t CH_SIGN  = 2'd1;
  localparam chr_t CH_ZERO  = 2'd2;
  localparam chr_t CH_DIGIT = 2'd3;

  // program steps
  localparam step_t ST_WAIT  = 4'd0;
  localparam step_t ST_CHECK = 4'd1;
  localparam step_t ST_CONV  = 4'd2;
  localparam step_t ST_LEN   = 4'd3;
  localparam step_t ST_PLAN  = 4'd4;
  localparam step_t ST_PADL  = 4'd5;
  localparam step_t ST_SIGN  = 4'd6;
  localparam step_t ST_PADZ  = 4'd7;
  localparam step_t ST_LEAD  = 4'd8;
  localparam step_t ST_DIG   = 4'd9;
  localparam step_t ST_PADR  = 4'd10;
  localparam step_t ST_DONE  = 4'd11;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    sel_t  sel;
    chr_t  chr;
    step_t jmp;
  } ucode_t;

  function automatic ucode_t ucode(input step_t s);
    ucode_t u;
    case (s)
      ST_WAIT:  u = '{OP_WAIT,  C_NOXFER,  SEL_PADL, CH_SPACE, ST_WAIT};
      ST_CHECK: u = '{OP_CHECK, C_BADKIND, SEL_PADL, CH_SPACE, ST_WAIT};
      ST_CONV:  u = '{OP_CONV,  C_CONV_NZ, SEL_PADL, CH_SPACE, ST_CONV};
      ST_LEN:   u = '{OP_LEN,   C_NEVER,   SEL_PADL, CH_SPACE, ST_WAIT};
      ST_PLAN:  u = '{OP_PLAN,  C_NEVER,   SEL_PADL, CH_SPACE, ST_WAIT};
      ST_PADL:  u = '{OP_EMIT,  C_SEG_NZ,  SEL_PADL, CH_SPACE, ST_PADL};
      ST_SIGN:  u = '{OP_EMIT,  C_SEG_NZ,  SEL_SIGN, CH_SIGN,  ST_SIGN};
      ST_PADZ:  u = '{OP_EMIT,  C_SEG_NZ,  SEL_PADZ, CH_ZERO,  ST_PADZ};
      ST_LEAD:  u = '{OP_EMIT,  C_SEG_NZ,  SEL_LEAD, CH_ZERO,  ST_LEAD};
      ST_DIG:   u = '{OP_EMIT,  C_SEG_NZ,  SEL_DIG,  CH_DIGIT, ST_DIG};
      ST_PADR:  u = '{OP_EMIT,  C_SEG_NZ,  SEL_PADR, CH_SPACE, ST_PADR};
      default:  u = '{OP_NOP,   C_ALWAYS,  SEL_PADL, CH_SPACE, ST_WAIT};
    endcase
    return u;
  endfunction

  function automatic logic [6:0] size_bits(input logic [2:0] code);
    logic [6:0] b;
    case (code)
      SIZE_CHAR:  b = 7'd8;
      SIZE_SHORT: b = 7'd16;
      SIZE_LONG:  b = 7'(LONG_BITS);
      SIZE_LLONG: b = 7'd64;
      default:    b = 7'd32;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ASC_ZERO + {4'd0, d};
    end else if (upper) begin
      c = ASC_UA + {4'd0, d - 4'd10};
    end else begin
      c = ASC_LA + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

[hw/rtl/itf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_if: channel interfaces of the integer to text formatter
// Request channel and character channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface itf_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [2:0]        size_code;
  logic [63:0]       raw_value;
  logic              left_align;
  logic              force_plus;
  logic              space_sign;
  logic              zero_fill;
  logic [5:0]        field_width;
  logic signed [6:0] min_digits;

  modport source (
    output valid, kind, size_code, raw_value, left_align, force_plus,
           space_sign, zero_fill, field_width, min_digits,
    input  ready
  );
  modport sink (
    input  valid, kind, size_code, raw_value, left_align, force_plus,
           space_sign, zero_fill, field_width, min_digits,
    output ready
  );
endinterface

interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

[hw/rtl/integer_to_text_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_formatter: printf-style integer conversion
// Microcoded sequencer that turns one request into a stream of ASCII chars.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | kind, size, value, flags, width, precision
//  out_ch   | out | valid/ready   | character, last
//
//  Per request: accept, check, the conversion step (repeated for decimal,
//  four double-dabble bits at a time, plus a pass to leave), length and
//  plan, then one emit step per output segment (six), each sending that
//  segment's characters, and a finish step; an unknown kind returns to the
//  wait step after the check. in_ch.ready is high only in the wait step.
//  Reset is synchronous and returns the program to the wait step;
//  a stalled out_ch holds the emit step.
// ----------------------------------------------------------------------------
module integer_to_text_formatter (
  input  logic        clk,
  input  logic        rst_n,
  itf_in_if.sink      in_ch,
  itf_out_if.source   out_ch
);

  itf_pkg::step_t  step_r, step_nxt;
  itf_pkg::ucode_t uc;

  logic [2:0]                          kind_r, kind_nxt;
  logic [itf_pkg::VAL_W-1:0]           num_r, num_nxt;
  logic [itf_pkg::NUM_DIGITS-1:0][3:0] dig_r, dig_nxt;
  logic [itf_pkg::CV_W-1:0]            cv_r, cv_nxt;
  logic                                sgn_r, sgn_nxt;
  logic [7:0]                          sgn_chr_r, sgn_chr_nxt;
  logic                                left_r, left_nxt;
  logic                                zf_r, zf_nxt;
  logic [itf_pkg::CNT_W-1:0]           width_r, width_nxt;
  logic                                pen_r, pen_nxt;
  logic [itf_pkg::CNT_W-1:0]           pval_r, pval_nxt;
  logic [itf_pkg::CNT_W-1:0]           cnt_r [itf_pkg::NUM_SEGS];
  logic [itf_pkg::CNT_W-1:0]           cnt_nxt [itf_pkg::NUM_SEGS];
  logic [itf_pkg::CNT_W-1:0]           rem_r, rem_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [7:0]                          out_char_r, out_char_nxt;
  logic                                out_last_r, out_last_nxt;

  logic                            in_xfer;
  logic                            slot_free;
  logic [itf_pkg::CNT_W-1:0]       cur_cnt;
  logic                            take;
  logic [6:0]                      bits;
  logic [6:0]                      bits_m1;
  logic [itf_pkg::VAL_W-1:0]       mask;
  logic [itf_pkg::VAL_W-1:0]       masked;
  logic                            neg;
  logic [itf_pkg::VAL_W+1:0]       oct_ext;
  logic [itf_pkg::DEC_DIGITS*4-1:0] bcd;
  logic [itf_pkg::VAL_W-1:0]       bin;
  logic [itf_pkg::CNT_W-1:0]       len;
  logic                            any_nz;
  logic [itf_pkg::CNT_W-1:0]       dlen;
  logic [itf_pkg::CNT_W-1:0]       lead;
  logic [itf_pkg::CNT_W-1:0]       body;
  logic [itf_pkg::CNT_W-1:0]       pad;
  logic                            zf_eff;
  logic [itf_pkg::DIG_IDX_W-1:0]   dig_idx;
  logic [7:0]                      emit_chr;

  assign uc        = itf_pkg::ucode(step_r);
  assign in_ch.ready = (uc.op == itf_pkg::OP_WAIT);
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cur_cnt   = cnt_r[uc.sel];
  assign dig_idx   = cnt_r[itf_pkg::SEL_DIG][itf_pkg::DIG_IDX_W-1:0] - 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  // request narrowing and sign handling
  always_comb begin
    bits    = itf_pkg::size_bits(in_ch.size_code);
    bits_m1 = bits - 7'd1;
    for (int i = 0; i < itf_pkg::VAL_W; i++) begin
      mask[i] = (7'(i) < bits);
    end
    masked  = in_ch.raw_value & mask;
    neg     = (in_ch.kind == itf_pkg::KIND_SDEC) && masked[bits_m1[5:0]];
    oct_ext = {2'b00, num_r};
  end

  // four double-dabble steps per cycle
  always_comb begin
    bcd = '0;
    for (int j = 0; j < itf_pkg::DEC_DIGITS; j++) begin
      bcd[4*j +: 4] = dig_r[j];
    end
    bin = num_r;
    for (int k = 0; k < itf_pkg::DABBLE_BITS; k++) begin
      for (int j = 0; j < itf_pkg::DEC_DIGITS; j++) begin
        if (bcd[4*j +: 4] >= 4'd5) begin
          bcd[4*j +: 4] = bcd[4*j +: 4] + 4'd3;
        end
      end
      bcd = {bcd[itf_pkg::DEC_DIGITS*4-2:0], bin[itf_pkg::VAL_W-1]};
      bin = {bin[itf_pkg::VAL_W-2:0], 1'b0};
    end
  end

  // significant digit count
  always_comb begin
    len    = '0;
    any_nz = 1'b0;
    for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
      if (dig_r[i] != 4'd0) begin
        len    = itf_pkg::CNT_W'(i + 1);
        any_nz = 1'b1;
      end
    end
    if (!any_nz) begin
      len = (pen_r && pval_r == '0) ? '0 : itf_pkg::CNT_W'(1);
    end
  end

  // field layout
  always_comb begin
    dlen   = cnt_r[itf_pkg::SEL_DIG];
    lead   = (pen_r && pval_r > dlen) ? pval_r - dlen : '0;
    body   = {{(itf_pkg::CNT_W-1){1'b0}}, sgn_r} + lead + dlen;
    pad    = (width_r > body) ? width_r - body : '0;
    zf_eff = zf_r && !pen_r && !left_r;
  end

  always_comb begin
    case (uc.chr)
      itf_pkg::CH_SPACE: emit_chr = itf_pkg::ASC_SPACE;
      itf_pkg::CH_SIGN:  emit_chr = sgn_chr_r;
      itf_pkg::CH_ZERO:  emit_chr = itf_pkg::ASC_ZERO;
      itf_pkg::CH_DIGIT: emit_chr = itf_pkg::digit_char(dig_r[dig_idx],
                                      kind_r == itf_pkg::KIND_HEXU);
      default:           emit_chr = itf_pkg::ASC_SPACE;
    endcase
  end

  always_comb begin
    case (uc.cond)
      itf_pkg::C_NEVER:   take = 1'b0;
      itf_pkg::C_ALWAYS:  take = 1'b1;
      itf_pkg::C_NOXFER:  take = !in_xfer;
      itf_pkg::C_BADKIND: take = (kind_r > itf_pkg::KIND_HEXU);
      itf_pkg::C_CONV_NZ: take = (cv_r != '0);
      itf_pkg::C_SEG_NZ:  take = (cur_cnt != '0);
      default:            take = 1'b0;
    endcase
    step_nxt = take ? uc.jmp : step_r + 4'd1;
  end

  // datapath
  always_comb begin
    kind_nxt    = kind_r;
    num_nxt     = num_r;
    dig_nxt     = dig_r;
    cv_nxt      = cv_r;
    sgn_nxt     = sgn_r;
    sgn_chr_nxt = sgn_chr_r;
    left_nxt    = left_r;
    zf_nxt      = zf_r;
    width_nxt   = width_r;
    pen_nxt     = pen_r;
    pval_nxt    = pval_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (uc.op)
      itf_pkg::OP_WAIT: begin
        if (in_xfer) begin
          kind_nxt  = in_ch.kind;
          num_nxt   = neg ? (~masked & mask) + 64'd1 : masked;
          left_nxt  = in_ch.left_align;
          zf_nxt    = in_ch.zero_fill;
          width_nxt = (in_ch.field_width > itf_pkg::CNT_W'(itf_pkg::MAX_WIDTH)) ?
                      itf_pkg::CNT_W'(itf_pkg::MAX_WIDTH) : in_ch.field_width;
          pen_nxt   = !in_ch.min_digits[6];
          pval_nxt  = (in_ch.min_digits[5:0] > itf_pkg::CNT_W'(itf_pkg::MAX_PREC)) ?
                      itf_pkg::CNT_W'(itf_pkg::MAX_PREC) : in_ch.min_digits[5:0];
          sgn_nxt   = (in_ch.kind == itf_pkg::KIND_SDEC) &&
                      (neg || in_ch.force_plus || in_ch.space_sign);
          if (neg) begin
            sgn_chr_nxt = itf_pkg::ASC_MINUS;
          end else if (in_ch.force_plus) begin
            sgn_chr_nxt = itf_pkg::ASC_PLUS;
          end else begin
            sgn_chr_nxt = itf_pkg::ASC_SPACE;
          end
        end
      end
      itf_pkg::OP_CHECK: begin
        dig_nxt = '0;
        cv_nxt  = '0;
        if (kind_r == itf_pkg::KIND_SDEC || kind_r == itf_pkg::KIND_UDEC) begin
          cv_nxt = itf_pkg::CV_W'(itf_pkg::DABBLE_STEPS);
        end else if (kind_r == itf_pkg::KIND_OCT) begin
          for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
            dig_nxt[i] = {1'b0, oct_ext[3*i +: 3]};
          end
        end else begin
          for (int i = 0; i < itf_pkg::VAL_W / 4; i++) begin
            dig_nxt[i] = num_r[4*i +: 4];
          end
        end
      end
      itf_pkg::OP_CONV: begin
        if (cv_r != '0) begin
          for (int j = 0; j < itf_pkg::DEC_DIGITS; j++) begin
            dig_nxt[j] = bcd[4*j +: 4];
          end
          num_nxt = bin;
          cv_nxt  = cv_r - 1'b1;
        end
      end
      itf_pkg::OP_LEN: begin
        cnt_nxt[itf_pkg::SEL_DIG] = len;
      end
      itf_pkg::OP_PLAN: begin
        cnt_nxt[itf_pkg::SEL_PADL] = (!left_r && !zf_eff) ? pad : '0;
        cnt_nxt[itf_pkg::SEL_SIGN] = {{(itf_pkg::CNT_W-1){1'b0}}, sgn_r};
        cnt_nxt[itf_pkg::SEL_PADZ] = (!left_r && zf_eff) ? pad : '0;
        cnt_nxt[itf_pkg::SEL_LEAD] = lead;
        cnt_nxt[itf_pkg::SEL_PADR] = left_r ? pad : '0;
        rem_nxt = body + pad;
      end
      itf_pkg::OP_EMIT: begin
        if (cur_cnt != '0 && slot_free) begin
          out_valid_nxt    = 1'b1;
          out_char_nxt     = emit_chr;
          out_last_nxt     = (rem_r == itf_pkg::CNT_W'(1));
          cnt_nxt[uc.sel]  = cur_cnt - 1'b1;
          rem_nxt          = rem_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= itf_pkg::ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    num_r      <= num_nxt;
    dig_r      <= dig_nxt;
    cv_r       <= cv_nxt;
    sgn_r      <= sgn_nxt;
    sgn_chr_r  <= sgn_chr_nxt;
    left_r     <= left_nxt;
    zf_r       <= zf_nxt;
    width_r    <= width_nxt;
    pen_r      <= pen_nxt;
    pval_r     <= pval_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[hw/rtl/itf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_checker: port-level checks for the integer to text formatter
// Watches both channels and flags ordering and character-set slips.
// ----------------------------------------------------------------------------
module itf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_last
);

  // a stalled character stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output changed");

  // one request at a time
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted twice in a row");

  // back in the wait step only the final character may still be pending
  a_ready_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("new request taken before conversion finished");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_character == itf_pkg::ASC_SPACE) || (out_character == itf_pkg::ASC_PLUS) ||
      (out_character == itf_pkg::ASC_MINUS) ||
      (out_character >= itf_pkg::ASC_ZERO && out_character <= itf_pkg::ASC_NINE) ||
      (out_character >= itf_pkg::ASC_UA && out_character <= itf_pkg::ASC_UF) ||
      (out_character >= itf_pkg::ASC_LA && out_character <= itf_pkg::ASC_LF))
    else $error("unexpected output character");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);
